// ===== rtl/core/bitp_pkg.sv =====
// Shared types, character codes and decode functions for the Boolean
// infix-to-postfix converter. No dependencies.
package bitp_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	// Stack entry codes: opening parenthesis, or operator coded by priority
	localparam logic [2:0] ENTRY_OPEN = 3'd0;
	localparam logic [2:0] PRIO_EQV   = 3'd1;
	localparam logic [2:0] PRIO_IMP   = 3'd2;
	localparam logic [2:0] PRIO_OR    = 3'd3;
	localparam logic [2:0] PRIO_AND   = 3'd4;
	localparam logic [2:0] PRIO_NOT   = 3'd5;

	localparam logic [7:0] CH_NOT    = 8'h21; // !
	localparam logic [7:0] CH_AND    = 8'h26; // &
	localparam logic [7:0] CH_LPAR   = 8'h28; // (
	localparam logic [7:0] CH_RPAR   = 8'h29; // )
	localparam logic [7:0] CH_ZERO   = 8'h30; // 0
	localparam logic [7:0] CH_ONE    = 8'h31; // 1
	localparam logic [7:0] CH_IMP    = 8'h3E; // >
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_OR     = 8'h7C; // |
	localparam logic [7:0] CH_EQV    = 8'h7E; // ~
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_OPEN  = 3'd1,
		ST_UNCLOSED = 3'd2,
		ST_UNKNOWN  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_SPACE,
		K_OPERAND,
		K_OPER,
		K_OPEN,
		K_CLOSE,
		K_BAD,
		K_FLUSH
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_OPER,
		S_CLOSE,
		S_FLUSH
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] prio;
		logic [7:0] code;
	} char_class_t;

	typedef struct packed {
		logic [7:0] token_code;
		logic       token_valid;
		logic       end_of_postfix;
		status_t    status;
	} token_t;

	typedef struct packed {
		logic   valid;
		token_t tok;
	} emit_t;

	function automatic char_class_t classify(input logic [7:0] c);
		logic [7:0]  u;
		char_class_t r;
		u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
		r.kind = K_BAD;
		r.prio = ENTRY_OPEN;
		r.code = u;
		if (c <= CH_SPACE || c[7]) begin
			r.kind = K_SPACE;
		end else if ((u >= CH_UPPER_A && u <= CH_UPPER_Z) || u == CH_ZERO || u == CH_ONE) begin
			r.kind = K_OPERAND;
		end else begin
			case (u)
				CH_NOT: begin r.kind = K_OPER; r.prio = PRIO_NOT; end
				CH_AND: begin r.kind = K_OPER; r.prio = PRIO_AND; end
				CH_OR:  begin r.kind = K_OPER; r.prio = PRIO_OR;  end
				CH_IMP: begin r.kind = K_OPER; r.prio = PRIO_IMP; end
				CH_EQV: begin r.kind = K_OPER; r.prio = PRIO_EQV; end
				CH_LPAR: r.kind = K_OPEN;
				CH_RPAR: r.kind = K_CLOSE;
				default: r.kind = K_BAD;
			endcase
		end
		return r;
	endfunction

	function automatic logic [7:0] entry_char(input logic [2:0] e);
		logic [7:0] ch;
		case (e)
			ENTRY_OPEN: ch = CH_LPAR;
			PRIO_EQV:   ch = CH_EQV;
			PRIO_IMP:   ch = CH_IMP;
			PRIO_OR:    ch = CH_OR;
			PRIO_AND:   ch = CH_AND;
			PRIO_NOT:   ch = CH_NOT;
			default:    ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/core/bitp_if.sv =====
// Valid/ready channel interfaces for formula bytes and postfix tokens.
// No dependencies.
interface bitp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface bitp_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_code;
	logic       token_valid;
	logic       end_of_postfix;
	logic [2:0] status;

	modport source (output valid, output token_code, output token_valid,
		output end_of_postfix, output status, input ready);
	modport sink (input valid, input token_code, input token_valid,
		input end_of_postfix, input status, output ready);
endinterface

// ===== rtl/core/bitp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bitp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/bitp_ctrl.sv =====
// Shunting-yard sequencer: decodes bytes, keeps the stack top in a register
// and the rest in the stack RAM. Depends on bitp_pkg, bitp_if.
module bitp_ctrl #(
	parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bitp_char_if.sink                      char_ch,
	input  logic                           out_free,
	output bitp_pkg::emit_t                emit,
	output logic                           ram_we,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
	output logic [2:0]                     ram_wdata,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
	input  logic [2:0]                     ram_rdata
);
	import bitp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t      state_q, state_d;
	logic [CW-1:0] count_q, count_d, count_m1, count_m2;
	logic [2:0]  top_q;
	logic        discard_q;
	logic [2:0]  prio_q;
	logic        end_q;
	logic        fwd_q;
	logic [2:0]  fwd_data_q;

	char_class_t cls;
	kind_t       cur_kind;
	logic [2:0]  cur_prio;
	logic        cur_end;
	logic        active;
	logic        accept;
	logic [2:0]  below;
	logic        stack_full, has_oper_top, top_ge;
	logic        do_pop, do_push, do_clear;
	logic [2:0]  push_val;
	status_t     err;

	assign cls = classify(char_ch.char_code);
	assign char_ch.ready = (state_q == S_IDLE) && out_free;
	assign accept = char_ch.valid && char_ch.ready;

	always_comb begin
		cur_kind = K_FLUSH;
		cur_prio = prio_q;
		cur_end  = end_q;
		active   = out_free;
		case (state_q)
			S_IDLE: begin
				cur_kind = cls.kind;
				cur_prio = cls.prio;
				cur_end  = char_ch.end_of_text;
				active   = accept && !discard_q;
			end
			S_OPER:  cur_kind = K_OPER;
			S_CLOSE: cur_kind = K_CLOSE;
			S_FLUSH: cur_kind = K_FLUSH;
			default: active = 1'b0;
		endcase
	end

	// entry just under the top; forward a write that landed on the read address
	assign below        = fwd_q ? fwd_data_q : ram_rdata;
	assign stack_full   = count_q >= CW'(STACK_DEPTH);
	assign has_oper_top = (count_q != '0) && (top_q != ENTRY_OPEN);
	assign top_ge       = has_oper_top && (top_q >= cur_prio);

	// actions and emitted beat
	always_comb begin
		emit     = '0;
		do_pop   = 1'b0;
		do_push  = 1'b0;
		do_clear = 1'b0;
		push_val = cur_prio;
		err      = ST_OK;
		if (active) begin
			case (cur_kind)
				K_OPERAND: begin
					emit.valid = 1'b1;
					emit.tok.token_code = cls.code;
					emit.tok.token_valid = 1'b1;
				end
				K_OPER: begin
					if (top_ge) begin
						do_pop = 1'b1;
						emit.valid = 1'b1;
						emit.tok.token_code = entry_char(top_q);
						emit.tok.token_valid = 1'b1;
					end else if (stack_full) begin
						err = ST_OVERFLOW;
					end else begin
						do_push = 1'b1;
					end
				end
				K_OPEN: begin
					push_val = ENTRY_OPEN;
					if (stack_full) begin
						err = ST_OVERFLOW;
					end else begin
						do_push = 1'b1;
					end
				end
				K_CLOSE: begin
					if (has_oper_top) begin
						do_pop = 1'b1;
						emit.valid = 1'b1;
						emit.tok.token_code = entry_char(top_q);
						emit.tok.token_valid = 1'b1;
					end else if (count_q == '0) begin
						err = ST_NO_OPEN;
					end else begin
						do_pop = 1'b1; // drop the matching opening paren
					end
				end
				K_FLUSH: begin
					if (has_oper_top) begin
						do_pop = 1'b1;
						emit.valid = 1'b1;
						emit.tok.token_code = entry_char(top_q);
						emit.tok.token_valid = 1'b1;
					end else begin
						do_clear = 1'b1;
						emit.valid = 1'b1;
						emit.tok.end_of_postfix = 1'b1;
						emit.tok.status = (count_q == '0) ? ST_OK : ST_UNCLOSED;
					end
				end
				K_BAD: err = ST_UNKNOWN;
				default: ;
			endcase
			if (err != ST_OK) begin
				do_pop   = 1'b0;
				do_push  = 1'b0;
				do_clear = 1'b1;
				emit     = '0;
				emit.valid = 1'b1;
				emit.tok.end_of_postfix = 1'b1;
				emit.tok.status = err;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (active) begin
			case (cur_kind)
				K_OPER: begin
					if (top_ge) begin
						state_d = S_OPER;
					end else if (stack_full || !cur_end) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_FLUSH;
					end
				end
				K_CLOSE: begin
					if (has_oper_top) begin
						state_d = S_CLOSE;
					end else if (count_q == '0 || !cur_end) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_FLUSH;
					end
				end
				K_FLUSH: state_d = has_oper_top ? S_FLUSH : S_IDLE;
				K_OPEN:  state_d = (stack_full || !cur_end) ? S_IDLE : S_FLUSH;
				K_OPERAND, K_SPACE: state_d = cur_end ? S_FLUSH : S_IDLE;
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_clear || (accept && discard_q && char_ch.end_of_text)) begin
			count_d = '0;
		end else if (do_pop) begin
			count_d = count_q - CW'(1);
		end else if (do_push) begin
			count_d = count_q + CW'(1);
		end
	end

	assign count_m1  = count_q - CW'(1);
	assign count_m2  = count_d - CW'(2);
	// push moves the old top down into the RAM
	assign ram_we    = do_push && (count_q != '0);
	assign ram_waddr = count_m1[AW-1:0];
	assign ram_wdata = top_q;
	assign ram_raddr = count_m2[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			discard_q <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			fwd_q   <= ram_we && (ram_waddr == ram_raddr);
			if (accept && discard_q && char_ch.end_of_text) begin
				discard_q <= 1'b0;
			end else if (active && err != ST_OK && !cur_end) begin
				discard_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
		if (do_pop) begin
			top_q <= below;
		end else if (do_push) begin
			top_q <= push_val;
		end
		if (accept) begin
			prio_q <= cls.prio;
			end_q  <= char_ch.end_of_text;
		end
	end

endmodule

// ===== rtl/core/boolean_infix_to_postfix_unit.sv =====
// Tokens are registered: each appears in the cycle after it is produced.
// Bytes are taken at one per cycle when idle and the output is free; a byte
// that pops operators, or an end byte, holds off the next byte until done.
// Results leave at one per cycle, gated by the output register and its ready.
// Reset clears the sequencer, stack count and discard flag; the stack RAM is
// not cleared (entries above the count are never read).
module boolean_infix_to_postfix_unit #(
	parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bitp_char_if.sink     char_ch,
	bitp_token_if.source  token_ch
);
	import bitp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	emit_t         emit;
	logic          out_free;
	logic          out_valid_q;
	token_t        out_tok_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [2:0]    ram_wdata, ram_rdata;

	assign out_free = !out_valid_q || token_ch.ready;

	bitp_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_ch   (char_ch),
		.out_free  (out_free),
		.emit      (emit),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bitp_ram #(
		.WIDTH(3),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: take a new beat whenever the old one is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			out_tok_q <= emit.tok;
		end
	end

	assign token_ch.valid          = out_valid_q;
	assign token_ch.token_code     = out_tok_q.token_code;
	assign token_ch.token_valid    = out_tok_q.token_valid;
	assign token_ch.end_of_postfix = out_tok_q.end_of_postfix;
	assign token_ch.status         = out_tok_q.status;

endmodule
